// ===== hw/rtl/lpfd_pkg.sv =====
// lpfd_pkg: shared types and constants for the length-prefixed frame deframer
// no dependencies; imported by length_prefixed_frame_deframer
package lpfd_pkg;

   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 32;
   localparam int LenBytes    = LenWidth / ByteWidth;
   localparam int MaxLenWidth = 24;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [MaxLenWidth-1:0] MaxLenReset = 24'd65535;

   // csr register indexes (word addressed, paddr[2])
   localparam logic CsrIdxMaxLen = 1'b0;

   // result kinds
   typedef enum logic [1:0] {
      KIND_HEAD    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

endpackage

// ===== hw/rtl/length_prefixed_frame_deframer.sv =====
// length_prefixed_frame_deframer: splits a byte stream of length-prefixed frames
// into tagged head and payload bytes; depends on lpfd_pkg
//
// usage:
//   req_*  : one received stream byte per request in req_tdata
//   rsp_*  : at most one result per request; rsp_tuser carries the kind
//            (head, payload, empty-frame marker, invalid-frame marker),
//            rsp_tdata the byte (zero for markers), rsp_tlast the frame end
//   csr_*  : one register, max_payload_len at byte address 0
// frame format: 4-byte big-endian total length, head-length byte H, H head
// bytes, then total - H - 1 payload bytes
// result: registered; it appears in the cycle after the request that causes it
// throughput: one request per cycle while req_tready is high, set by the single parse register stage;
//   length bytes and the head-length byte of a non-empty valid frame give no
//   result
// stall: the result register accepts a new request while the held result is
//   taken in the same cycle; with rsp_tready low and a result held, req_tready
//   drops until it is taken
// reset: parser returns to collecting length bytes, no result held,
//   max_payload_len goes back to 65535
// the user must write max_payload_len only while no request is in flight; not enforced
module length_prefixed_frame_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpfd_pkg::ByteWidth-1:0]       req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lpfd_pkg::ByteWidth-1:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]                           rsp_tuser,   // [1:0] kind
   output logic                                 rsp_tlast,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lpfd_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [lpfd_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [lpfd_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import lpfd_pkg::*;

   // parse phases
   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,   // collecting the four length bytes
      PH_HLEN = 2'd1,   // waiting for the head-length byte
      PH_HEAD = 2'd2,   // head bytes, delivered or swallowed
      PH_PAY  = 2'd3    // payload bytes
   } phase_type;

   localparam int CntWidth = $clog2(LenBytes);

   // parser state
   phase_type                phase_ff, phase_in;
   logic [LenWidth-1:0]      len_acc_ff, len_acc_in;
   logic [CntWidth-1:0]      len_cnt_ff, len_cnt_in;
   logic [ByteWidth-1:0]     head_rem_ff, head_rem_in;
   logic [MaxLenWidth-1:0]   pay_rem_ff, pay_rem_in;
   logic                     frame_valid_ff, frame_valid_in;

   // configuration
   logic [MaxLenWidth-1:0]   max_len_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 rsp_kind_ff, rsp_kind_in;
   logic [ByteWidth-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_fire;
   logic                     emit;
   logic [LenWidth-1:0]      pay_diff;
   logic                     frame_bad;
   logic                     csr_write;

   // result register frees up when empty or being taken this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // payload length of the frame now starting: positive total minus H minus one;
   // a total with bit 31 set is negative and always bad
   assign pay_diff  = {1'b0, len_acc_ff[LenWidth-2:0]}
                      - LenWidth'(req_tdata) - LenWidth'(1);
   assign frame_bad = len_acc_ff[LenWidth-1] || pay_diff[LenWidth-1]
                      || (pay_diff[LenWidth-2:0] > (LenWidth-1)'(max_len_ff));

   // next parser state and result for the byte in req_tdata
   always_comb begin
      phase_in       = phase_ff;
      len_acc_in     = len_acc_ff;
      len_cnt_in     = len_cnt_ff;
      head_rem_in    = head_rem_ff;
      pay_rem_in     = pay_rem_ff;
      frame_valid_in = frame_valid_ff;
      emit           = 1'b0;
      rsp_kind_in    = KIND_HEAD;
      rsp_byte_in    = req_tdata;
      rsp_last_in    = 1'b0;

      case (phase_ff)
         PH_LEN: begin
            // shift in big-endian length bytes
            len_acc_in = {len_acc_ff[LenWidth-ByteWidth-1:0], req_tdata};
            if (len_cnt_ff == CntWidth'(LenBytes - 1)) begin
               len_cnt_in = '0;
               phase_in   = PH_HLEN;
            end else begin
               len_cnt_in = len_cnt_ff + CntWidth'(1);
            end
         end
         PH_HLEN: begin
            len_acc_in  = '0;
            head_rem_in = req_tdata;
            if (frame_bad) begin
               // report once, then swallow the head bytes
               frame_valid_in = 1'b0;
               pay_rem_in     = '0;
               phase_in       = (req_tdata != '0) ? PH_HEAD : PH_LEN;
               emit           = 1'b1;
               rsp_kind_in    = KIND_INVALID;
               rsp_byte_in    = '0;
               rsp_last_in    = 1'b1;
            end else begin
               frame_valid_in = 1'b1;
               pay_rem_in     = pay_diff[MaxLenWidth-1:0];
               if (req_tdata != '0) begin
                  phase_in = PH_HEAD;
               end else if (pay_diff[MaxLenWidth-1:0] != '0) begin
                  phase_in = PH_PAY;
               end else begin
                  // no head, no payload
                  phase_in    = PH_LEN;
                  emit        = 1'b1;
                  rsp_kind_in = KIND_EMPTY;
                  rsp_byte_in = '0;
                  rsp_last_in = 1'b1;
               end
            end
         end
         PH_HEAD: begin
            head_rem_in = (head_rem_ff <= ByteWidth'(1)) ? '0 : head_rem_ff - ByteWidth'(1);
            if (head_rem_ff <= ByteWidth'(1)) begin
               phase_in = (frame_valid_ff && pay_rem_ff != '0) ? PH_PAY : PH_LEN;
            end
            emit        = frame_valid_ff;
            rsp_kind_in = KIND_HEAD;
            rsp_last_in = (head_rem_ff <= ByteWidth'(1)) && (pay_rem_ff == '0);
         end
         PH_PAY: begin
            pay_rem_in  = (pay_rem_ff <= MaxLenWidth'(1)) ? '0 : pay_rem_ff - MaxLenWidth'(1);
            if (pay_rem_ff <= MaxLenWidth'(1)) begin
               phase_in = PH_LEN;
            end
            emit        = 1'b1;
            rsp_kind_in = KIND_PAYLOAD;
            rsp_last_in = (pay_rem_ff <= MaxLenWidth'(1));
         end
         default: begin
            phase_in = PH_LEN;
         end
      endcase
   end

   // result valid: loaded on each request, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN;
         len_acc_ff     <= '0;
         len_cnt_ff     <= '0;
         head_rem_ff    <= '0;
         pay_rem_ff     <= '0;
         frame_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff       <= phase_in;
            len_acc_ff     <= len_acc_in;
            len_cnt_ff     <= len_cnt_in;
            head_rem_ff    <= head_rem_in;
            pay_rem_ff     <= pay_rem_in;
            frame_valid_ff <= frame_valid_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   // configuration port, csr_pready always high
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else if (csr_write && csr_paddr[2] == CsrIdxMaxLen) begin
         max_len_ff <= csr_pwdata[MaxLenWidth-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CsrIdxMaxLen) ? CsrDataWidth'(max_len_ff) : '0;

   // length byte count only runs while collecting the length
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_LEN) |-> (len_cnt_ff == '0))
      else $error("length byte count nonzero outside length phase");

   // payload phase never entered or kept with nothing left
   a_pay_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (pay_rem_ff != '0))
      else $error("payload phase with no payload left");

   // head phase always has a byte left to take
   a_head_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEAD) |-> (head_rem_ff != '0))
      else $error("head phase with no head bytes left");

   // markers carry a zero byte and close the frame
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_EMPTY || rsp_kind_ff == KIND_INVALID))
      |-> (rsp_byte_ff == '0 && rsp_last_ff))
      else $error("frame marker with data or without last");

   // payload bytes only come from a valid frame
   a_pay_valid: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> frame_valid_ff)
      else $error("payload phase for an invalid frame");

endmodule
